// ===== rtl/core/assembly_source_tokenizer_unit_macros.svh =====
// Assertion macros used by the checker file of the tokenizer unit.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_UNIT_MACROS_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define ASUT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASUT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/asut_pkg.sv =====
// Package of the assembly source tokenizer unit: result types, scan mode codes,
// character constants and character class functions. Depends on nothing.
`timescale 1ns / 1ps

package asut_pkg;

    localparam int MaxResults = 3;

    // Scan mode codes.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_WORD  = 3'd1;
    localparam logic [2:0] MODE_DEC   = 3'd2;
    localparam logic [2:0] MODE_HEX   = 3'd3;
    localparam logic [2:0] MODE_STR_E = 3'd4;
    localparam logic [2:0] MODE_STR_C = 3'd5;
    localparam logic [2:0] MODE_HALT  = 3'd6;

    // Number prefix codes.
    localparam logic [1:0] PFX_NONE      = 2'd0;
    localparam logic [1:0] PFX_MINUS     = 2'd1;
    localparam logic [1:0] PFX_MINUS_ZERO = 2'd2;
    localparam logic [1:0] PFX_ZERO      = 2'd3;

    // Token kinds.
    localparam logic [1:0] KIND_IDENT  = 2'd0;
    localparam logic [1:0] KIND_LABEL  = 2'd1;
    localparam logic [1:0] KIND_NUMBER = 2'd2;
    localparam logic [1:0] KIND_STRING = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NEG_HEX   = 2'd1;
    localparam logic [1:0] ERR_OPEN_STR  = 2'd2;

    // Characters.
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic       has_char;
        logic [7:0] token_char;
        logic       token_start;
        logic       token_end;
        logic [1:0] token_kind;
        logic [15:0] line_no;
        logic [1:0] error_code;
        logic       run_last;
    } result_t;

    // Results caused by one input character, in delivery order.
    typedef struct packed {
        result_t [MaxResults-1:0] res;
        logic [1:0]               count;
    } bundle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_numch(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_MINUS);
    endfunction

    function automatic logic is_hexch(input logic [7:0] c);
        return is_numch(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

// ===== rtl/core/asut_text_if.sv =====
// Interfaces of the tokenizer unit: the source text channel and the token channel.
// Depends on nothing; payload fields are plain vectors.
`timescale 1ns / 1ps

interface asut_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       text_end;

    modport source (output valid, output ch, output text_end, input ready);
    modport sink (input valid, input ch, input text_end, output ready);
endinterface

interface asut_token_if;
    logic        valid;
    logic        ready;
    logic        has_char;
    logic [7:0]  token_char;
    logic        token_start;
    logic        token_end;
    logic [1:0]  token_kind;
    logic [15:0] line_no;
    logic [1:0]  error_code;
    logic        run_last;

    modport source (output valid, output has_char, output token_char, output token_start,
                    output token_end, output token_kind, output line_no,
                    output error_code, output run_last, input ready);
    modport sink (input valid, input has_char, input token_char, input token_start,
                  input token_end, input token_kind, input line_no,
                  input error_code, input run_last, output ready);
endinterface

// ===== rtl/core/asut_scan.sv =====
// Scanner of the tokenizer unit: mode, prefix and line registers and the per-character
// step logic that builds the bundle of results. Depends on asut_pkg.
`timescale 1ns / 1ps

module asut_scan #(
    parameter int LINE_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       ch,
    input  logic             text_end,
    output asut_pkg::bundle_t bundle
);
    import asut_pkg::*;

    localparam int LineExtBits = (LINE_BITS > 16) ? LINE_BITS : 16;

    logic [2:0]           mode_reg, mode_next, mode_mid;
    logic [1:0]           prefix_reg, prefix_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LineExtBits-1:0] line_ext;
    logic [15:0]          line_no;
    logic                 idle_pass;
    logic                 a_v, b_v, c_v;
    result_t              a_res, b_res, c_res;
    result_t              r0, r1, r2;
    logic [1:0]           count;

    assign line_ext = LineExtBits'(line_reg);
    assign line_no  = (line_ext > LineExtBits'(16'hFFFF)) ? 16'hFFFF : line_ext[15:0];

    function automatic result_t mk(input logic has, input logic [7:0] c, input logic start,
                                   input logic fin, input logic [1:0] kind,
                                   input logic [1:0] err, input logic [15:0] line);
        result_t r;
        r.has_char    = has;
        r.token_char  = c;
        r.token_start = start;
        r.token_end   = fin;
        r.token_kind  = kind;
        r.line_no     = line;
        r.error_code  = err;
        r.run_last    = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        mode_mid    = mode_reg;
        prefix_next = prefix_reg;
        line_next   = line_reg;
        idle_pass   = 1'b0;
        a_v = 1'b0;
        b_v = 1'b0;
        c_v = 1'b0;
        a_res = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_IDENT, ERR_NONE, line_no);
        b_res = a_res;
        c_res = a_res;

        case (mode_reg)
            MODE_WORD:
            begin
                a_v = 1'b1;
                if (is_letter(ch))
                begin
                    a_res = mk(1'b1, ch, 1'b0, 1'b0, KIND_IDENT, ERR_NONE, line_no);
                end
                else if (ch == CH_COLON)
                begin
                    a_res    = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_LABEL, ERR_NONE, line_no);
                    mode_mid = MODE_IDLE;
                end
                else
                begin
                    a_res     = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_IDENT, ERR_NONE, line_no);
                    mode_mid  = MODE_IDLE;
                    idle_pass = 1'b1;
                end
            end
            MODE_DEC:
            begin
                a_v = 1'b1;
                if ((ch == CH_X) && (prefix_reg == PFX_MINUS_ZERO))
                begin
                    a_res    = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_NUMBER, ERR_NEG_HEX, line_no);
                    mode_mid = MODE_HALT;
                end
                else if ((ch == CH_X) && (prefix_reg == PFX_ZERO))
                begin
                    a_res       = mk(1'b1, ch, 1'b0, 1'b0, KIND_NUMBER, ERR_NONE, line_no);
                    mode_mid    = MODE_HEX;
                    prefix_next = PFX_NONE;
                end
                else if (is_numch(ch))
                begin
                    a_res       = mk(1'b1, ch, 1'b0, 1'b0, KIND_NUMBER, ERR_NONE, line_no);
                    prefix_next = ((prefix_reg == PFX_MINUS) && (ch == CH_ZERO))
                                  ? PFX_MINUS_ZERO : PFX_NONE;
                end
                else
                begin
                    a_res       = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_NUMBER, ERR_NONE, line_no);
                    mode_mid    = MODE_IDLE;
                    prefix_next = PFX_NONE;
                    idle_pass   = 1'b1;
                end
            end
            MODE_HEX:
            begin
                a_v = 1'b1;
                if (is_hexch(ch))
                begin
                    a_res = mk(1'b1, ch, 1'b0, 1'b0, KIND_NUMBER, ERR_NONE, line_no);
                end
                else
                begin
                    a_res     = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_NUMBER, ERR_NONE, line_no);
                    mode_mid  = MODE_IDLE;
                    idle_pass = 1'b1;
                end
            end
            MODE_STR_E, MODE_STR_C:
            begin
                a_v = 1'b1;
                if (ch == CH_QUOTE)
                begin
                    a_res    = mk(1'b0, 8'h00, mode_reg == MODE_STR_E, 1'b1, KIND_STRING,
                                  ERR_NONE, line_no);
                    mode_mid = MODE_IDLE;
                end
                else
                begin
                    a_res    = mk(1'b1, ch, mode_reg == MODE_STR_E, 1'b0, KIND_STRING,
                                  ERR_NONE, line_no);
                    mode_mid = MODE_STR_C;
                end
            end
            MODE_IDLE:
            begin
                idle_pass = 1'b1;
            end
            default:
            begin
                // Halted: characters are ignored until the end of the text.
            end
        endcase

        if (idle_pass)
        begin
            if (ch == CH_NEWLINE)
            begin
                if (line_reg != {LINE_BITS{1'b1}})
                begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end
            else if (is_letter(ch))
            begin
                b_v      = 1'b1;
                b_res    = mk(1'b1, ch, 1'b1, 1'b0, KIND_IDENT, ERR_NONE, line_no);
                mode_mid = MODE_WORD;
            end
            else if (is_numch(ch))
            begin
                b_v      = 1'b1;
                b_res    = mk(1'b1, ch, 1'b1, 1'b0, KIND_NUMBER, ERR_NONE, line_no);
                mode_mid = MODE_DEC;
                if (ch == CH_MINUS)
                begin
                    prefix_next = PFX_MINUS;
                end
                else if (ch == CH_ZERO)
                begin
                    prefix_next = PFX_ZERO;
                end
                else
                begin
                    prefix_next = PFX_NONE;
                end
            end
            else if (ch == CH_QUOTE)
            begin
                mode_mid = MODE_STR_E;
            end
        end

        mode_next = mode_mid;
        if (text_end)
        begin
            case (mode_mid)
                MODE_WORD:
                begin
                    c_v   = 1'b1;
                    c_res = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_IDENT, ERR_NONE, line_no);
                end
                MODE_DEC, MODE_HEX:
                begin
                    c_v   = 1'b1;
                    c_res = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_NUMBER, ERR_NONE, line_no);
                end
                MODE_STR_E:
                begin
                    c_v   = 1'b1;
                    c_res = mk(1'b0, 8'h00, 1'b1, 1'b1, KIND_STRING, ERR_OPEN_STR, line_no);
                end
                MODE_STR_C:
                begin
                    c_v   = 1'b1;
                    c_res = mk(1'b0, 8'h00, 1'b0, 1'b1, KIND_STRING, ERR_OPEN_STR, line_no);
                end
                default:
                begin
                    c_v = 1'b0;
                end
            endcase
            mode_next   = MODE_IDLE;
            prefix_next = PFX_NONE;
            line_next   = '0;
        end
    end

    // Pack the valid slots to the front, in order, and mark the last one.
    always_comb
    begin
        count = 2'(a_v) + 2'(b_v) + 2'(c_v);
        r0 = a_v ? a_res : (b_v ? b_res : c_res);
        r1 = (a_v && b_v) ? b_res : c_res;
        r2 = c_res;
        case (count)
            2'd1:    r0.run_last = 1'b1;
            2'd2:    r1.run_last = 1'b1;
            2'd3:    r2.run_last = 1'b1;
            default: r0.run_last = 1'b0;
        endcase
        bundle.res   = {r2, r1, r0};
        bundle.count = count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            prefix_reg <= PFX_NONE;
            line_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            line_reg   <= line_next;
        end
    end

endmodule

// ===== rtl/core/asut_out_queue.sv =====
// Result queue of the tokenizer unit: holds the bundle of one character and hands its
// results out one per cycle while the receiver is ready. Depends on asut_pkg.
`timescale 1ns / 1ps

module asut_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  asut_pkg::bundle_t bundle,
    output logic              load_ready,
    output logic              valid,
    input  logic              ready,
    output asut_pkg::result_t head
);
    import asut_pkg::*;

    result_t [MaxResults-1:0] res_reg, res_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic                     take;

    assign take       = (cnt_reg != 2'd0) && ready;
    assign load_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && ready);
    assign valid      = (cnt_reg != 2'd0);
    assign head       = res_reg[0];

    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            res_next = bundle.res;
            cnt_next = bundle.count;
        end
        else if (take)
        begin
            res_next = {res_reg[2], res_reg[2], res_reg[1]};
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== rtl/core/assembly_source_tokenizer_unit.sv =====
// Assembly source tokenizer unit: the top level, joining the scanner and the result queue.
// Depends on asut_pkg, asut_text_if, asut_token_if, asut_scan and asut_out_queue.
//
// Usage: source text enters on the text channel, one byte per transaction, with text_end
// set on the final byte of a text. Token characters and token end markers leave on the
// tokens channel, one result per transaction, each carrying the line number it was
// found on; run_last marks the final result caused by one input byte.
// Latency: the first result of a byte is offered in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte causes at most one result and the
// receiver is ready. A byte that causes two or three results (a token end plus a new
// token start, and a close at text end) holds the text channel until its last result is
// being taken: the queue holds one byte's results and hands them out one per ready cycle.
// A byte is taken while the last result of the previous byte is being taken, so a
// steady stream of single-result bytes flows without bubbles.
// Reset clears the scan mode, the number prefix, the line counter and the result queue;
// the block takes bytes in the first cycle after reset is released.
// When the receiver stalls, the pending result stays on the port unchanged and the
// text channel is held off once no room is left for the next byte's results.
`timescale 1ns / 1ps

module assembly_source_tokenizer_unit #(
    parameter int LINE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    asut_text_if.sink     text,
    asut_token_if.source  tokens
);
    import asut_pkg::*;

    bundle_t bundle;
    result_t head;
    logic    step;
    logic    load_ready;

    // A byte is accepted when the queue can take all of its results.
    assign text.ready = load_ready;
    assign step       = text.valid && load_ready;

    asut_scan #(
        .LINE_BITS (LINE_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .ch       (text.ch),
        .text_end (text.text_end),
        .bundle   (bundle)
    );

    asut_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .bundle     (bundle),
        .load_ready (load_ready),
        .valid      (tokens.valid),
        .ready      (tokens.ready),
        .head       (head)
    );

    // Drive the token channel payload from the head of the queue.
    assign tokens.has_char    = head.has_char;
    assign tokens.token_char  = head.token_char;
    assign tokens.token_start = head.token_start;
    assign tokens.token_end   = head.token_end;
    assign tokens.token_kind  = head.token_kind;
    assign tokens.line_no     = head.line_no;
    assign tokens.error_code  = head.error_code;
    assign tokens.run_last    = head.run_last;

endmodule

// ===== rtl/core/asut_checker.sv =====
// Port checker of the tokenizer unit, attached to the top level by a bind statement.
// Depends on assembly_source_tokenizer_unit_macros.svh and the top level's ports.
`timescale 1ns / 1ps
`include "assembly_source_tokenizer_unit_macros.svh"

module asut_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        has_char,
    input logic [7:0]  token_char,
    input logic        token_end,
    input logic [1:0]  error_code,
    input logic        run_last
);
    // A stalled result stays offered with the same character and run_last flag.
    `ASUT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(token_char) && $stable(run_last), "stalled result changed")

    // More results of the same byte remain, so no new byte may be taken.
    `ASUT_ASSERT_IMPL(a_no_early_take, out_valid && !run_last, !in_ready,
        "byte taken while earlier results are pending")

    // A result that is not the last of its byte is followed by another.
    `ASUT_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid,
        "result run ended without run_last")

    // Errors only appear on a closing marker that ends the run of its byte.
    `ASUT_ASSERT_IMPL(a_error_marker, out_valid && (error_code != 2'd0),
        token_end && !has_char && run_last, "error on a result that is not a final marker")

endmodule

bind assembly_source_tokenizer_unit asut_checker u_asut_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (text.ready),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .has_char   (tokens.has_char),
    .token_char (tokens.token_char),
    .token_end  (tokens.token_end),
    .error_code (tokens.error_code),
    .run_last   (tokens.run_last)
);
